FILE: sv/b64lw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the character table of the Base64 line-wrap
// encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

    // Character codes
    localparam logic [7:0] CH_PAD            = 8'd61;   // '='
    localparam logic [7:0] CH_LF             = 8'd10;   // line feed
    localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
    localparam logic [8:0] GROUP_CHARS       = 9'd4;    // characters per full group

    // Command queue between front and back
    localparam int Q_DEPTH = 2;                          // power of two
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One command: up to four characters for the back end to send
    typedef struct packed {
        logic [3:0][7:0] chars;     // chars[0] goes out first
        logic [1:0]      last_idx;  // index of the final character (count - 1)
        logic            last;      // final command of the message
    } b64lw_cmd_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } b64lw_qstat_t;

    // Six-bit value to Base64 alphabet character
    function automatic logic [7:0] b64lw_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'd65 + w;               // A..Z
        end else if (v < 6'd52) begin
            return 8'd71 + w;               // a..z  ('a' - 26)
        end else if (v < 6'd62) begin
            return w - 8'd4;                // 0..9  ('0' - 52)
        end else if (v == 6'd62) begin
            return 8'd43;                   // '+'
        end else begin
            return 8'd47;                   // '/'
        end
    endfunction

endpackage

FILE: sv/b64lw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_front
// Takes input bytes, tracks the group phase, carried bits and line count,
// and turns each byte into one command of up to four characters.
// ----------------------------------------------------------------------------
module b64lw_front
    import b64lw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // line length register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // command output
    input  b64lw_qstat_t q_stat,
    output logic        cmd_push,
    output b64lw_cmd_t  cmd
);

    // Group phase codes
    localparam logic [1:0] PH_ZERO = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    logic [1:0] phase_reg,      phase_next;
    logic [3:0] carry_reg,      carry_next;
    logic [7:0] line_count_reg, line_count_next;
    logic [7:0] line_length_reg;
    logic [8:0] count_sum;
    logic       accept;

    assign s_ready  = !q_stat.full;
    assign accept   = s_valid && s_ready;
    assign cmd_push = accept;

    // Characters of this byte and the next encoder state
    always_comb begin
        cmd             = '0;
        cmd.last        = s_last_byte;
        phase_next      = phase_reg;
        carry_next      = carry_reg;
        line_count_next = line_count_reg;
        count_sum       = {1'b0, line_count_reg} + GROUP_CHARS;
        case (phase_reg)
            PH_ONE: begin
                cmd.chars[0] = b64lw_sym({carry_reg[1:0], s_data_byte[7:4]});
                if (s_last_byte) begin
                    cmd.chars[1] = b64lw_sym({s_data_byte[3:0], 2'b00});
                    cmd.chars[2] = CH_PAD;
                    cmd.last_idx = 2'd2;
                end else begin
                    cmd.last_idx = 2'd0;
                    carry_next   = s_data_byte[3:0];
                    phase_next   = PH_TWO;
                end
            end
            PH_TWO: begin
                cmd.chars[0] = b64lw_sym({carry_reg, s_data_byte[7:6]});
                cmd.chars[1] = b64lw_sym(s_data_byte[5:0]);
                // group complete: wrap once the line is long enough
                if (count_sum >= {1'b0, line_length_reg}) begin
                    cmd.chars[2]    = CH_LF;
                    cmd.last_idx    = 2'd2;
                    line_count_next = '0;
                end else begin
                    cmd.last_idx    = 2'd1;
                    line_count_next = count_sum[7:0];
                end
                carry_next = '0;
                phase_next = PH_ZERO;
            end
            default: begin
                cmd.chars[0] = b64lw_sym(s_data_byte[7:2]);
                if (s_last_byte) begin
                    cmd.chars[1] = b64lw_sym({s_data_byte[1:0], 4'b0000});
                    cmd.chars[2] = CH_PAD;
                    cmd.chars[3] = CH_PAD;
                    cmd.last_idx = 2'd3;
                end else begin
                    cmd.last_idx = 2'd0;
                    carry_next   = {2'b00, s_data_byte[1:0]};
                    phase_next   = PH_ONE;
                end
            end
        endcase
        // end of message: fresh group on a fresh line
        if (s_last_byte) begin
            phase_next      = PH_ZERO;
            carry_next      = '0;
            line_count_next = '0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_ZERO;
            carry_reg       <= '0;
            line_count_reg  <= '0;
            line_length_reg <= LINE_LENGTH_RESET;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                carry_reg      <= carry_next;
                line_count_reg <= line_count_next;
            end
            if (cfg_wr_en) begin
                line_length_reg <= cfg_wr_data;
            end
        end
    end

    // Checks
    a_msg_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> (phase_reg == PH_ZERO && line_count_reg == 8'd0
                                     && carry_reg == 4'd0))
        else $error("state not cleared after end of message");

    a_count_whole_groups: assert property (@(posedge aclk) disable iff (!aresetn)
        line_count_reg[1:0] == 2'b00)
        else $error("line count is not a whole number of groups");

    a_carry_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ONE) |-> (carry_reg[3:2] == 2'b00))
        else $error("stray carried bits in phase one");

endmodule

FILE: sv/b64lw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_queue
// Short command queue that decouples the byte front end from the character
// back end.
// ----------------------------------------------------------------------------
module b64lw_queue
    import b64lw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  b64lw_cmd_t   push_cmd,
    input  logic         pop,
    output b64lw_cmd_t   head_cmd,
    output b64lw_qstat_t q_stat
);

    b64lw_cmd_t         mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_cmd     = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill count beyond depth");

    a_no_lost_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("push into a full queue");

endmodule

FILE: sv/b64lw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_back
// Walks the characters of the command at the queue head and sends them one
// per cycle, while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module b64lw_back
    import b64lw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  b64lw_cmd_t   head_cmd,
    input  b64lw_qstat_t q_stat,
    output logic         pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_out_char,
    output logic         m_last_char
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;

    // Load the next character whenever a command waits and the output register is free
    assign load   = !q_stat.empty && (!valid_reg || m_ready);
    assign at_end = (idx_reg == head_cmd.last_idx);
    assign pop    = load && at_end;

    assign m_valid     = valid_reg;
    assign m_out_char  = char_reg;
    assign m_last_char = last_reg;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= head_cmd.chars[idx_reg];
            last_reg <= head_cmd.last && at_end;
        end
    end

    // Checks
    a_mid_cmd_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 2'd0) |-> !q_stat.empty)
        else $error("character index set with no command at the head");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_stat.empty |-> (idx_reg <= head_cmd.last_idx))
        else $error("character index past the end of the command");

endmodule

FILE: sv/base64_encoder_line_wrap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap_core
// Streaming Base64 encoder with line feeds after complete groups.
// ----------------------------------------------------------------------------
// A byte can be taken in every cycle while the two-entry command queue has
// room; the back end sends one character per cycle while the output is ready
// and a command waits, so the sustained rate is set by the output, line feeds
// and pads included. A character passes through a queue entry and then the
// output register after its byte is taken. line_length (reset 76) is compared
// after every complete group; a final partial group is padded with '=' and
// never wraps. The last character of a message carries m_last_char.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap_core
    import b64lw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_char
);

    b64lw_qstat_t q_stat;
    b64lw_cmd_t   push_cmd;
    b64lw_cmd_t   head_cmd;
    logic         push;
    logic         pop;

    // Byte front end
    b64lw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_stat      (q_stat),
        .cmd_push    (push),
        .cmd         (push_cmd)
    );

    // Command queue
    b64lw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // Character back end
    b64lw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (head_cmd),
        .q_stat      (q_stat),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

endmodule

FILE: verif/tb_base64_encoder_line_wrap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_encoder_line_wrap_core
// Self-checking bench for the streaming Base64 encoder with line wrapping.
// ----------------------------------------------------------------------------
// Messages of raw bytes are queued phase by phase and sent by a clocked
// driver with random gaps. Every byte taken by the encoder is run through a
// local encoder model that appends the characters it should produce, line
// feeds and pads included, to a queue. A clocked monitor with random
// back-pressure compares each character transfer with the head of that queue.
// line_length is changed between phases, only once all characters are out,
// covering the reset value, both ends of the byte range and a change in the
// middle of a message. One phase holds the output off for a long stretch so
// that the encoder fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_base64_encoder_line_wrap_core;
    import b64lw_pkg::*;

    // One raw byte waiting to be sent, and one expected character
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } raw_byte_t;

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
    } enc_char_t;

    localparam int BURST_CYCLES = 300;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'd0;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_char;
    logic       m_last_char;

    // Stimulus and expectation stores
    raw_byte_t  byte_q [$];
    enc_char_t  char_q [$];
    raw_byte_t  next_byte;
    enc_char_t  want_char;

    // Local encoder state
    logic [1:0] grp;
    logic [3:0] carry;
    logic [7:0] col;
    logic [7:0] wrap_len;
    string      b64_set =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Pacing controls, set by the sequence, driver and monitor, read by driver and monitor
    bit calm_in = 1'b0;
    bit calm_out = 1'b0;
    bit burst_req = 1'b0;
    bit burst_done = 1'b0;
    int in_gap = 0;
    int out_gap = 0;
    int burst_left = 0;
    int err_count = 0;

    base64_encoder_line_wrap_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] enc_sym(input logic [5:0] v);
        return b64_set[int'(v)];
    endfunction

    // Characters caused by one byte, appended to the expectation queue
    task automatic predict_byte(input logic [7:0] b, input logic fin);
        logic [7:0] outs [$];
        logic [8:0] col_next;
        case (grp)
            2'd1: begin
                outs.push_back(enc_sym({carry[1:0], b[7:4]}));
                if (fin) begin
                    outs.push_back(enc_sym({b[3:0], 2'b00}));
                    outs.push_back(CH_PAD);
                end else begin
                    carry = b[3:0];
                    grp   = 2'd2;
                end
            end
            2'd2: begin
                outs.push_back(enc_sym({carry, b[7:6]}));
                outs.push_back(enc_sym(b[5:0]));
                // full group done: count it and wrap if the line is long enough
                col_next = {1'b0, col} + GROUP_CHARS;
                if (col_next >= {1'b0, wrap_len}) begin
                    outs.push_back(CH_LF);
                    col_next = 9'd0;
                end
                col   = col_next[7:0];
                carry = 4'd0;
                grp   = 2'd0;
            end
            default: begin
                outs.push_back(enc_sym(b[7:2]));
                if (fin) begin
                    outs.push_back(enc_sym({b[1:0], 4'b0000}));
                    outs.push_back(CH_PAD);
                    outs.push_back(CH_PAD);
                end else begin
                    carry = {2'b00, b[1:0]};
                    grp   = 2'd1;
                end
            end
        endcase
        foreach (outs[i])
            char_q.push_back('{code: outs[i], fin: fin && (i == outs.size() - 1)});
        // end of message: next byte opens a fresh line
        if (fin) begin
            grp   = 2'd0;
            carry = 4'd0;
            col   = 8'd0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 30)
            $display("%0t mismatch on %0s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic queue_byte(input logic [7:0] d, input logic fin);
        byte_q.push_back('{data: d, fin: fin});
    endtask

    // Random message body; close marks the final byte
    task automatic queue_message(input int len, input bit close);
        int r;
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            queue_byte(d, close && (i == len - 1));
        end
    endtask

    // Mostly short messages, some long enough to wrap at the default width;
    // the last message is trimmed so the phase stays within its budget
    task automatic queue_random_traffic(input int budget);
        int n;
        int r;
        int len;
        n = 0;
        while (n < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(1, 9);
            else if (r < 92) len = $urandom_range(10, 30);
            else             len = $urandom_range(50, 90);
            if (len > budget - n)
                len = budget - n;
            queue_message(len, 1'b1);
            n += len;
        end
        // sometimes leave a message open across the next register change
        if ($urandom_range(0, 1) == 1)
            queue_message($urandom_range(1, 2), 1'b0);
    endtask

    // Wait until everything sent has come out, then let the block settle
    task automatic settle();
        while (byte_q.size() != 0 || s_valid || char_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_line_length(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        wrap_len     = v;
        calm_in      = ($urandom_range(0, 3) == 0);
        calm_out     = ($urandom_range(0, 3) == 0);
    endtask

    // Driver: presents queued bytes, predicts on every transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_byte(s_data_byte, s_last_byte);
            if (!s_valid || s_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    next_byte    = byte_q.pop_front();
                    s_valid     <= 1'b1;
                    s_data_byte <= next_byte.data;
                    s_last_byte <= next_byte.fin;
                    in_gap       = calm_in ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each character transfer and paces m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (char_q.size() == 0) begin
                    report_mismatch("unexpected character", m_out_char, 0);
                end else begin
                    want_char = char_q.pop_front();
                    if (m_out_char !== want_char.code)
                        report_mismatch("out_char", m_out_char, want_char.code);
                    if (m_last_char !== want_char.fin)
                        report_mismatch("last_char", m_last_char, want_char.fin);
                end
                out_gap = calm_out ? 0 : pick_gap();
            end
            // one long hold-off on request, otherwise random stalls
            if (burst_req && !burst_done) begin
                burst_done  = 1'b1;
                burst_left  = BURST_CYCLES;
                m_ready    <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                m_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial begin
        grp      = 2'd0;
        carry    = 4'd0;
        col      = 8'd0;
        wrap_len = LINE_LENGTH_RESET;
        calm_in  = 1'b1;
        calm_out = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // default width: single bytes, two bytes, group closed by the last byte
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b1);
        settle();

        // one-group width: line feed on the last character, wrap then pads
        write_line_length(8'd4);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h56, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hBE, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b1);
        settle();

        // zero width wraps after every group; leave a message open
        write_line_length(8'd0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h55, 1'b0);
        settle();

        // width change in the middle of a message, then random traffic
        write_line_length(8'd255);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h0F, 1'b1);
        queue_random_traffic(12);
        settle();

        // widest legal line with a long hold-off on the output
        write_line_length(8'd252);
        calm_in   = 1'b1;
        burst_req = 1'b1;
        queue_message(196, 1'b1);
        settle();
        burst_req = 1'b0;

        write_line_length(LINE_LENGTH_RESET);
        queue_random_traffic(70);
        settle();

        write_line_length(8'd1);
        queue_random_traffic(12);
        settle();

        write_line_length(8'd8);
        queue_random_traffic(16);
        settle();

        write_line_length(8'd5);
        queue_random_traffic(12);
        settle();

        write_line_length(8'($urandom_range(4, 252)));
        queue_random_traffic(24);
        settle();

        write_line_length(8'($urandom_range(0, 255)));
        queue_random_traffic(16);
        settle();

        repeat (20) @(posedge aclk);
        if (err_count == 0 && char_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
